[rtl/core/ufr_pkg.sv]
// Package of the underexposed frame replacer.
// Holds the register map, the fixed field widths and the APB port sizes.
// No dependencies.
package ufr_pkg;

  localparam int DoseW    = 16;
  localparam int PprW     = 13;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;
  localparam int RegIdxLsb = 2;

  localparam logic [PprW-1:0] PprReset = PprW'(4096);

  typedef enum logic {
    REG_DOSE_THRESHOLD   = 1'b0,
    REG_PIXELS_PER_FRAME = 1'b1
  } ufr_reg_e;

endpackage

[rtl/core/ufr_if.sv]
// Stream interfaces of the underexposed frame replacer: input pixel items
// and result items, each with valid/ready handshake.
// Depends on ufr_pkg for the dose width.
interface ufr_in_if
  import ufr_pkg::*;
#(
  parameter int SampleW = 16
);
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] pixel_value;
  logic [DoseW-1:0]   frame_dose;
  logic               first_frame;
  logic               last_frame;

  modport source (output valid, pixel_value, frame_dose, first_frame, last_frame,
                  input ready);
  modport sink   (input valid, pixel_value, frame_dose, first_frame, last_frame,
                  output ready);
endinterface

interface ufr_out_if
  import ufr_pkg::*;
#(
  parameter int SampleW = 16
);
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] out_pixel;
  logic [DoseW-1:0]   out_dose;
  logic               replaced;
  logic               stack_end;

  modport source (output valid, out_pixel, out_dose, replaced, stack_end,
                  input ready);
  modport sink   (input valid, out_pixel, out_dose, replaced, stack_end,
                  output ready);
endinterface

[rtl/core/ufr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (old data on a same-address collision). No dependencies.
module ufr_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/underexposed_frame_replacer_unit.sv]
// Top level of the underexposed frame replacer: frame hold, neighbour average
// replacement and APB register file. Depends on ufr_pkg, ufr_if and ufr_ram.
//
//   channel  | direction | handshake        | payload
//   in_i     | in        | valid/ready      | pixel_value, frame_dose, first/last_frame
//   out_o    | out       | valid/ready      | out_pixel, out_dose, replaced, stack_end
//   apb      | in        | psel/penable     | paddr, pwdata, prdata
//
// One item per cycle while the result stage is not held; an item of a last frame
// that also releases a held pixel gives two results and holds the result stage
// until both are sent. Item enters, reads both frame stores (registered read
// data), then writes back and moves its results into the output register; the
// earliest result passes the result stage, then the output register.
// Stores need no clearing pass; control state clears on rst_ni.
// Output stall holds the result stage while it has a result, which holds the input.
module underexposed_frame_replacer_unit
  import ufr_pkg::*;
#(
  parameter int MAX_PIXELS  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ufr_in_if.sink              in_i,
  ufr_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int PosW = $clog2(MAX_PIXELS);
  localparam int CntW = $clog2(MAX_PIXELS + 1);
  localparam int SzW  = (CntW > PprW) ? CntW : PprW;

  // configuration
  logic [DoseW-1:0] thr_q;
  logic [PprW-1:0]  ppf_q;
  ufr_reg_e         reg_idx;

  assign reg_idx = ufr_reg_e'(paddr[RegIdxLsb]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      ppf_q <= PprReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_DOSE_THRESHOLD:   thr_q <= pwdata[DoseW-1:0];
        REG_PIXELS_PER_FRAME: ppf_q <= pwdata[PprW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DOSE_THRESHOLD:   prdata = ApbDataW'(thr_q);
      REG_PIXELS_PER_FRAME: prdata = ApbDataW'(ppf_q);
      default:              prdata = '0;
    endcase
  end

  // frame position
  logic [SzW-1:0]  ppf_ext;
  logic [SzW-1:0]  fsize;
  logic [PosW-1:0] pos_q, pos_d;
  logic            frame_end;
  logic            in_fire;

  assign ppf_ext   = SzW'(ppf_q);
  assign fsize     = (ppf_ext == '0) ? SzW'(1) :
                     (ppf_ext > SzW'(MAX_PIXELS)) ? SzW'(MAX_PIXELS) : ppf_ext;
  assign frame_end = (SzW'(pos_q) + SzW'(1)) >= fsize;
  assign pos_d     = frame_end ? '0 : pos_q + PosW'(1);
  assign in_fire   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_fire) begin
      pos_q <= pos_d;
    end
  end

  // result stage
  logic                   s1_valid_q, done0_q;
  logic [PosW-1:0]        s1_pos_q;
  logic [SAMPLE_BITS-1:0] s1_pix_q;
  logic [DoseW-1:0]       s1_dose_q;
  logic                   s1_first_q, s1_last_q, s1_end_q;
  logic                   fwd_prev_q, fwd_held_q;
  logic [SAMPLE_BITS-1:0] fwd_prev_data_q, fwd_held_data_q;

  logic [DoseW-1:0] prev_dose_q, held_dose_q;
  logic             held_under_q, held_first_q, holding_q;

  logic [SAMPLE_BITS-1:0] prev_rdata, held_rdata, prev_rd, held_rd;
  logic [SAMPLE_BITS:0]   pix_sum;
  logic [DoseW:0]         dose_sum;
  logic [SAMPLE_BITS-1:0] op;
  logic [DoseW-1:0]       od;
  logic                   rep, need0, out_free, s1_fire, load0, load1;
  logic                   prev_we, held_we;

  assign prev_rd  = fwd_prev_q ? fwd_prev_data_q : prev_rdata;
  assign held_rd  = fwd_held_q ? fwd_held_data_q : held_rdata;
  assign rep      = held_under_q && !held_first_q && !s1_first_q;
  assign pix_sum  = (SAMPLE_BITS + 1)'(prev_rd) + (SAMPLE_BITS + 1)'(s1_pix_q);
  assign dose_sum = (DoseW + 1)'(prev_dose_q) + (DoseW + 1)'(s1_dose_q);
  assign op       = rep ? pix_sum[SAMPLE_BITS:1] : held_rd;
  assign od       = rep ? dose_sum[DoseW:1] : held_dose_q;

  assign out_free = !out_o.valid || out_o.ready;
  assign need0    = holding_q && !done0_q;

  always_comb begin
    load0   = 1'b0;
    load1   = 1'b0;
    s1_fire = 1'b0;
    if (s1_valid_q) begin
      if (need0) begin
        load0   = out_free;
        s1_fire = out_free && !s1_last_q;
      end else if (s1_last_q) begin
        load1   = out_free;
        s1_fire = out_free;
      end else begin
        s1_fire = 1'b1;
      end
    end
  end

  assign in_i.ready = !s1_valid_q || s1_fire;
  assign prev_we    = s1_fire && holding_q;
  assign held_we    = s1_fire && !s1_last_q;

  ufr_ram #(.Width(SAMPLE_BITS), .Depth(MAX_PIXELS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (s1_pos_q),
    .wdata_i (op),
    .re_i    (in_fire),
    .raddr_i (pos_q),
    .rdata_o (prev_rdata)
  );

  ufr_ram #(.Width(SAMPLE_BITS), .Depth(MAX_PIXELS)) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (held_we),
    .waddr_i (s1_pos_q),
    .wdata_i (s1_pix_q),
    .re_i    (in_fire),
    .raddr_i (pos_q),
    .rdata_o (held_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      done0_q    <= 1'b0;
      fwd_prev_q <= 1'b0;
      fwd_held_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_prev_q <= prev_we && (s1_pos_q == pos_q);
        fwd_held_q <= held_we && (s1_pos_q == pos_q);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
        fwd_prev_q <= 1'b0;
        fwd_held_q <= 1'b0;
      end
      if (s1_fire) begin
        done0_q <= 1'b0;
      end else if (load0) begin
        done0_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pos_q        <= pos_q;
      s1_pix_q        <= in_i.pixel_value;
      s1_dose_q       <= in_i.frame_dose;
      s1_first_q      <= in_i.first_frame;
      s1_last_q       <= in_i.last_frame;
      s1_end_q        <= frame_end;
      fwd_prev_data_q <= op;
      fwd_held_data_q <= s1_pix_q;
    end
  end

  // frame state, advanced as the last item of each frame leaves the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_dose_q  <= '0;
      held_dose_q  <= '0;
      held_under_q <= 1'b0;
      held_first_q <= 1'b0;
      holding_q    <= 1'b0;
    end else if (s1_fire && s1_end_q) begin
      if (s1_last_q) begin
        holding_q <= 1'b0;
      end else begin
        if (holding_q) begin
          prev_dose_q <= od;
        end
        held_dose_q  <= s1_dose_q;
        held_under_q <= s1_dose_q < thr_q;
        held_first_q <= s1_first_q || !holding_q;
        holding_q    <= 1'b1;
      end
    end
  end

  // output register
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_pixel_q;
  logic [DoseW-1:0]       out_dose_q;
  logic                   out_repl_q, out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load0 || load1) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load0) begin
      out_pixel_q <= op;
      out_dose_q  <= od;
      out_repl_q  <= rep;
      out_end_q   <= 1'b0;
    end else if (load1) begin
      out_pixel_q <= s1_pix_q;
      out_dose_q  <= s1_dose_q;
      out_repl_q  <= 1'b0;
      out_end_q   <= s1_end_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_pixel = out_pixel_q;
  assign out_o.out_dose  = out_dose_q;
  assign out_o.replaced  = out_repl_q;
  assign out_o.stack_end = out_end_q;

`ifndef SYNTHESIS
  a_done0_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done0_q |-> (s1_valid_q && holding_q && s1_last_q))
    else $error("held result marked sent outside a two-result item");

  a_fwd_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fwd_prev_q || fwd_held_q) |-> s1_valid_q)
    else $error("store forwarding flagged with an empty result stage");

  a_pos_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && frame_end) |=> (pos_q == '0))
    else $error("pixel position not rewound at frame end");
`endif

endmodule
